>>> hdl/smrk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smrk_pkg;

    localparam int SMRK_DW   = 32;
    localparam int SMRK_FB   = 16;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int NCFG      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SOM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIND = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET [NCFG] = '{
        31'd655360, 31'd6554, 31'd6554, 31'd1310720, 31'd6554, 31'd1
    };

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TA1,
        ST_TA2,
        ST_TACC,
        ST_THX,
        ST_THV,
        ST_TFV,
        ST_TDV,
        ST_TFX,
        ST_TDX,
        ST_SSQ,
        ST_SRT,
        ST_SCMP,
        ST_SPM,
        ST_SPD,
        ST_SPF,
        ST_SPOS,
        ST_OUT
    } t_state;

endpackage
`default_nettype wire

>>> hdl/smrk_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module smrk_serial #(
    parameter int DATA_WIDTH = smrk_pkg::SMRK_DW
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  smrk_pkg::t_alu_req        i_req,
    input  logic [2*DATA_WIDTH-1:0]   i_a,
    input  logic [DATA_WIDTH-1:0]     i_b,
    output logic                      o_done,
    output logic [2*DATA_WIDTH-1:0]   o_res
);
    import smrk_pkg::*;

    localparam int DW  = DATA_WIDTH;
    localparam int W2  = 2 * DW;
    localparam int CNW = $clog2(W2 + 1);

    logic           r_busy;
    logic           r_fin;
    logic           r_done;
    t_alu_op        r_op;
    logic [CNW-1:0] r_cnt;
    logic [W2-1:0]  r_acc;
    logic [DW-1:0]  r_a;
    logic [DW-1:0]  r_b;
    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_root;

    logic [W2-1:0]  n_acc;
    logic [DW-1:0]  n_b;
    logic [DW:0]    n_rem;
    logic [DW-1:0]  n_root;

    logic [DW+1:0]  w_dv;
    logic [DW+1:0]  w_dsub;
    logic           w_dge;
    logic [DW+2:0]  w_sq;
    logic [DW+2:0]  w_tr;
    logic [DW+2:0]  w_ssub;
    logic           w_sge;
    logic           w_rnd;

    assign w_dv   = {r_rem, r_acc[W2-1]};
    assign w_dge  = w_dv >= {2'b00, r_b};
    assign w_dsub = w_dv - {2'b00, r_b};
    assign w_sq   = {r_rem, r_acc[W2-1:W2-2]};
    assign w_tr   = {1'b0, r_root, 2'b01};
    assign w_sge  = w_sq >= w_tr;
    assign w_ssub = w_sq - w_tr;
    assign w_rnd  = r_rem >= ({1'b0, r_b} - r_rem);

    always_comb begin
        n_acc  = r_acc;
        n_b    = r_b;
        n_rem  = r_rem;
        n_root = r_root;
        case (r_op)
            ALU_MUL: begin
                n_acc = {r_acc[W2-2:0], 1'b0} + {{DW{1'b0}}, (r_b[DW-1] ? r_a : {DW{1'b0}})};
                n_b   = {r_b[DW-2:0], 1'b0};
            end
            ALU_DIV: begin
                n_acc = {r_acc[W2-2:0], w_dge};
                n_rem = w_dge ? w_dsub[DW:0] : w_dv[DW:0];
            end
            ALU_SQRT: begin
                n_acc  = {r_acc[W2-3:0], 2'b00};
                n_rem  = w_sge ? w_ssub[DW:0] : w_sq[DW:0];
                n_root = {r_root[DW-2:0], w_sge};
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= ALU_MUL;
        end else begin
            r_done <= !i_req.start && r_busy
                      && (r_fin || ((r_cnt == CNW'(1)) && (r_op != ALU_DIV)));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_fin  <= 1'b0;
                r_op   <= i_req.op;
                r_cnt  <= (i_req.op == ALU_DIV) ? CNW'(W2) : CNW'(DW);
            end else if (r_busy) begin
                if (r_fin) begin
                    r_fin  <= 1'b0;
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNW'(1)) begin
                        if (r_op == ALU_DIV) begin
                            r_fin <= 1'b1;
                        end else begin
                            r_busy <= 1'b0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc  <= (i_req.op == ALU_MUL) ? {W2{1'b0}} : i_a;
            r_a    <= i_a[DW-1:0];
            r_b    <= i_b;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            if (r_fin) begin
                r_acc <= r_acc + {{(W2-1){1'b0}}, w_rnd};
            end else begin
                r_acc  <= n_acc;
                r_b    <= n_b;
                r_rem  <= n_rem;
                r_root <= n_root;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = (r_op == ALU_SQRT) ? {{DW{1'b0}}, r_root} : r_acc;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("serial unit restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && !r_fin)) else $error("done while still busy");

endmodule
`default_nettype wire

>>> hdl/spring_mass_rk4_contact_top.sv
// Damped spring mass with contact proxy, signed fixed point.
// Input channel i_valid/o_ready carries one request: opcode 0 advances the
// mass one RK4 step, opcode 1 is a stylus sample (i_stylus_x/y/z).
// Output channel o_valid/i_ready returns one result per request: mass
// position and velocity, contact force and proxy point after the request.
// Configuration is a write port (i_cfg_we, i_cfg_idx, i_cfg_data) with six
// registers; writes to indexes past the last are dropped.
// All arithmetic runs through one shared bit-serial unit for multiply,
// divide and square root.
// A tick costs 16 multiplies and 2 divides. A contact sample costs 3
// multiplies and a root, or 9, 3 divides and a root if MIND < dist <= RAD.
// One request is in work at a time; o_ready is high only between requests.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is taken, and that request finishes only once the
// output register is free.
// Reset (synchronous, active low) zeroes state and restores register
// defaults.
`timescale 1ns / 1ps
`default_nettype none
module spring_mass_rk4_contact_top #(
    parameter int DATA_WIDTH = smrk_pkg::SMRK_DW,
    parameter int FRAC_BITS  = smrk_pkg::SMRK_FB
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smrk_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [smrk_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic signed [DATA_WIDTH-1:0]        i_stylus_x,
    input  logic signed [DATA_WIDTH-1:0]        i_stylus_y,
    input  logic signed [DATA_WIDTH-1:0]        i_stylus_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [DATA_WIDTH-1:0]        o_mass_position,
    output logic signed [DATA_WIDTH-1:0]        o_mass_velocity,
    output logic signed [DATA_WIDTH-1:0]        o_force_x,
    output logic signed [DATA_WIDTH-1:0]        o_force_y,
    output logic signed [DATA_WIDTH-1:0]        o_force_z,
    output logic signed [DATA_WIDTH-1:0]        o_god_x,
    output logic signed [DATA_WIDTH-1:0]        o_god_y,
    output logic signed [DATA_WIDTH-1:0]        o_god_z
);
    import smrk_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int W2 = 2 * DW;
    localparam int EW = (DW > CFG_W) ? DW : CFG_W;
    localparam logic [DW-1:0] DMAX   = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] DMIN   = {1'b1, {(DW-1){1'b0}}};
    localparam logic [W2:0]   HALF_Q = (W2+1)'(1) << (FB - 1);
    localparam logic [W2:0]   HALF_H = (W2+1)'(1) << FB;
    localparam logic [DW-1:0] SIX    = DW'(6);

    function automatic logic [DW-1:0] f_mag(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] f_from_mag(input logic neg, input logic [W2:0] m);
        if (m > {{(W2+1-DW){1'b0}}, DMAX}) begin
            return neg ? DMIN : DMAX;
        end
        return neg ? (~m[DW-1:0] + 1'b1) : m[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_sadd(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? DMIN : DMAX;
        end
        return s[DW-1:0];
    endfunction

    function automatic logic [DW-1:0] f_ssub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} - {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            return s[DW] ? DMIN : DMAX;
        end
        return s[DW-1:0];
    endfunction

    // round to nearest, ties away from zero; half adds one extra shift
    function automatic logic [DW-1:0] f_round(input logic [W2-1:0] p, input logic half,
                                              input logic neg);
        logic [W2:0] t;
        t = {1'b0, p} + (half ? HALF_H : HALF_Q);
        t = half ? (t >> (FB + 1)) : (t >> FB);
        return f_from_mag(neg, t);
    endfunction

    function automatic logic [DW-1:0] f_reg(input logic [CFG_W-1:0] c);
        logic [EW-1:0] e;
        logic [EW-1:0] mx;
        e  = EW'(c);
        mx = EW'(DMAX);
        return (e > mx) ? DMAX : e[DW-1:0];
    endfunction

    t_state          r_state, n_state;
    logic            r_wait, n_wait;
    logic            r_ovalid;
    logic [CFG_W-1:0] r_cfg [NCFG];
    logic [DW-1:0]   r_pos, r_vel;
    logic [DW-1:0]   r_force [3];
    logic [DW-1:0]   r_god [3];
    logic [1:0]      r_stage;
    logic [1:0]      r_idx;

    logic [DW-1:0]   r_s [3];
    logic [DW-1:0]   r_yp;
    logic [DW-1:0]   r_xs, r_vs, r_a1, r_kv, r_sx, r_sv, r_tmp;
    logic [W2-1:0]   r_sum;
    logic [DW-1:0]   r_dist;
    logic            r_neg;

    logic [DW-1:0]   r_o_pos, r_o_vel;
    logic [DW-1:0]   r_o_force [3];
    logic [DW-1:0]   r_o_god [3];

    logic [DW-1:0]   w_som, w_dom, w_dt, w_rad, w_stf, w_mind;
    t_alu_req        w_req;
    logic [W2-1:0]   w_a;
    logic [DW-1:0]   w_b;
    logic            w_neg;
    logic            w_isop;
    logic            w_done;
    logic [W2-1:0]   w_res;
    logic [DW-1:0]   w_sqv;
    logic [DW-1:0]   w_diff;
    logic            w_accept;
    logic            w_out;

    assign w_som  = f_reg(r_cfg[CFG_SOM]);
    assign w_dom  = f_reg(r_cfg[CFG_DOM]);
    assign w_dt   = f_reg(r_cfg[CFG_DT]);
    assign w_rad  = f_reg(r_cfg[CFG_RAD]);
    assign w_stf  = f_reg(r_cfg[CFG_STF]);
    assign w_mind = f_reg(r_cfg[CFG_MIND]);

    assign w_sqv  = (r_idx == 2'd0) ? r_s[0] : ((r_idx == 2'd1) ? r_yp : r_s[2]);
    assign w_diff = f_ssub(r_god[r_idx], r_s[r_idx]);

    assign w_accept = i_valid && o_ready;
    assign w_out    = (r_state == ST_OUT) && (n_state == ST_IDLE);

    smrk_serial #(
        .DATA_WIDTH(DW)
    ) u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        w_req.op  = ALU_MUL;
        w_a       = '0;
        w_b       = '0;
        w_neg     = 1'b0;
        w_isop    = 1'b0;
        o_ready   = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_opcode ? ST_SSQ : ST_TA1;
                end
            end
            ST_TA1: begin
                w_isop = 1'b1;
                w_a    = W2'(w_som);
                w_b    = f_mag(r_xs);
                w_neg  = r_xs[DW-1];
                if (w_done) n_state = ST_TA2;
            end
            ST_TA2: begin
                w_isop = 1'b1;
                w_a    = W2'(w_dom);
                w_b    = f_mag(r_vs);
                w_neg  = r_vs[DW-1];
                if (w_done) n_state = ST_TACC;
            end
            ST_TACC: begin
                n_state = (r_stage == 2'd3) ? ST_TFV : ST_THX;
            end
            ST_THX: begin
                w_isop = 1'b1;
                w_a    = W2'(w_dt);
                w_b    = f_mag(r_vs);
                w_neg  = r_vs[DW-1];
                if (w_done) n_state = ST_THV;
            end
            ST_THV: begin
                w_isop = 1'b1;
                w_a    = W2'(w_dt);
                w_b    = f_mag(r_kv);
                w_neg  = r_kv[DW-1];
                if (w_done) n_state = ST_TA1;
            end
            ST_TFV: begin
                w_isop = 1'b1;
                w_a    = W2'(w_dt);
                w_b    = f_mag(r_sv);
                w_neg  = r_sv[DW-1];
                if (w_done) n_state = ST_TDV;
            end
            ST_TDV: begin
                w_isop   = 1'b1;
                w_req.op = ALU_DIV;
                w_a      = W2'(f_mag(r_tmp));
                w_b      = SIX;
                w_neg    = r_tmp[DW-1];
                if (w_done) n_state = ST_TFX;
            end
            ST_TFX: begin
                w_isop = 1'b1;
                w_a    = W2'(w_dt);
                w_b    = f_mag(r_sx);
                w_neg  = r_sx[DW-1];
                if (w_done) n_state = ST_TDX;
            end
            ST_TDX: begin
                w_isop   = 1'b1;
                w_req.op = ALU_DIV;
                w_a      = W2'(f_mag(r_tmp));
                w_b      = SIX;
                w_neg    = r_tmp[DW-1];
                if (w_done) n_state = ST_OUT;
            end
            ST_SSQ: begin
                w_isop = 1'b1;
                w_a    = W2'(f_mag(w_sqv));
                w_b    = f_mag(w_sqv);
                if (w_done && r_idx == 2'd2) n_state = ST_SRT;
            end
            ST_SRT: begin
                w_isop   = 1'b1;
                w_req.op = ALU_SQRT;
                w_a      = r_sum;
                if (w_done) n_state = ST_SCMP;
            end
            ST_SCMP: begin
                if (r_dist > w_rad) begin
                    n_state = ST_OUT;
                end else if (r_dist > w_mind) begin
                    n_state = ST_SPM;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_SPM: begin
                w_isop = 1'b1;
                w_a    = W2'(f_mag(r_s[r_idx]));
                w_b    = w_rad;
                w_neg  = r_s[r_idx][DW-1];
                if (w_done) n_state = ST_SPD;
            end
            ST_SPD: begin
                w_isop   = 1'b1;
                w_req.op = ALU_DIV;
                w_a      = r_sum;
                w_b      = r_dist;
                w_neg    = r_neg;
                if (w_done) n_state = ST_SPF;
            end
            ST_SPF: begin
                w_isop = 1'b1;
                w_a    = W2'(w_stf);
                w_b    = f_mag(w_diff);
                w_neg  = w_diff[DW-1];
                if (w_done) n_state = (r_idx == 2'd2) ? ST_SPOS : ST_SPM;
            end
            ST_SPOS: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || i_ready) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        w_req.start = w_isop && !r_wait;
        if (w_req.start) n_wait = 1'b1;
        if (w_done)      n_wait = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cfg    <= CFG_RESET;
            r_pos    <= '0;
            r_vel    <= '0;
            r_force  <= '{default: '0};
            r_god    <= '{default: '0};
            r_stage  <= '0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            if (i_cfg_we && (i_cfg_idx < CFG_IDX_W'(NCFG))) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end
            r_ovalid <= w_out || (r_ovalid && !i_ready);
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_stage <= '0;
                        r_idx   <= '0;
                    end
                end
                ST_THV: begin
                    if (w_done) r_stage <= r_stage + 1'b1;
                end
                ST_TDV: begin
                    if (w_done) r_vel <= f_sadd(r_vel, f_from_mag(r_neg, {1'b0, w_res}));
                end
                ST_TDX: begin
                    if (w_done) r_pos <= f_sadd(r_pos, f_from_mag(r_neg, {1'b0, w_res}));
                end
                ST_SSQ: begin
                    if (w_done) r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 1'b1;
                end
                ST_SCMP: begin
                    r_idx <= '0;
                    if (r_dist > w_rad) begin
                        r_god   <= r_s;
                        r_force <= '{default: '0};
                    end
                end
                ST_SPD: begin
                    if (w_done) r_god[r_idx] <= f_from_mag(r_neg, {1'b0, w_res});
                end
                ST_SPF: begin
                    if (w_done) begin
                        r_force[r_idx] <= f_round(w_res, 1'b0, r_neg);
                        r_idx          <= r_idx + 1'b1;
                    end
                end
                ST_SPOS: begin
                    r_pos <= f_sadd(r_pos, r_force[1]);
                end
                default: begin
                    r_stage <= r_stage;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req.start) r_neg <= w_neg;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_s[0] <= i_stylus_x;
                    r_s[1] <= i_stylus_y;
                    r_s[2] <= i_stylus_z;
                    r_yp   <= f_sadd(i_stylus_y, r_pos);
                    r_xs   <= r_pos;
                    r_vs   <= r_vel;
                end
            end
            ST_TA1: begin
                if (w_done) r_a1 <= f_round(w_res, 1'b0, r_neg);
            end
            ST_TA2: begin
                if (w_done) r_kv <= f_ssub(f_ssub('0, r_a1), f_round(w_res, 1'b0, r_neg));
            end
            ST_TACC: begin
                if (r_stage == 2'd0) begin
                    r_sx <= r_vs;
                    r_sv <= r_kv;
                end else if (r_stage == 2'd3) begin
                    r_sx <= f_sadd(r_sx, r_vs);
                    r_sv <= f_sadd(r_sv, r_kv);
                end else begin
                    r_sx <= f_sadd(r_sx, f_sadd(r_vs, r_vs));
                    r_sv <= f_sadd(r_sv, f_sadd(r_kv, r_kv));
                end
            end
            ST_THX: begin
                if (w_done) r_xs <= f_sadd(r_pos, f_round(w_res, r_stage != 2'd2, r_neg));
            end
            ST_THV: begin
                if (w_done) r_vs <= f_sadd(r_vel, f_round(w_res, r_stage != 2'd2, r_neg));
            end
            ST_TFV, ST_TFX: begin
                if (w_done) r_tmp <= f_round(w_res, 1'b0, r_neg);
            end
            ST_SSQ: begin
                if (w_done) r_sum <= (r_idx == 2'd0) ? w_res : r_sum + w_res;
            end
            ST_SRT: begin
                if (w_done) r_dist <= w_res[DW-1:0];
            end
            ST_SPM: begin
                if (w_done) r_sum <= w_res;
            end
            ST_OUT: begin
                if (w_out) begin
                    r_o_pos   <= r_pos;
                    r_o_vel   <= r_vel;
                    r_o_force <= r_force;
                    r_o_god   <= r_god;
                end
            end
            default: begin
                r_tmp <= r_tmp;
            end
        endcase
    end

    assign o_valid         = r_ovalid;
    assign o_mass_position = r_o_pos;
    assign o_mass_velocity = r_o_vel;
    assign o_force_x       = r_o_force[0];
    assign o_force_y       = r_o_force[1];
    assign o_force_z       = r_o_force[2];
    assign o_god_x         = r_o_god[0];
    assign o_god_y         = r_o_god[1];
    assign o_god_z         = r_o_god[2];

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready) else $error("second request taken while busy");
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_wait) else $error("serial unit finished with nothing pending");
    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out |=> o_valid) else $error("finished request not posted");

endmodule
`default_nettype wire
